/* rtl/rccm_pkg.sv */
// Shared constants, codes and pipeline payload types of the column texel mapper.
package rccm_pkg;

    localparam int SCR_H   = 480;
    localparam int AD_W    = $clog2(SCR_H + 1);
    localparam int NUM_W   = AD_W + 32;
    localparam int D_W     = AD_W + 32;
    localparam logic [NUM_W-1:0] WQ_NUM = NUM_W'(SCR_H) << 32;

    localparam int C_W     = 11;
    localparam int WN_W    = 28;
    localparam int WD_W    = 17;
    localparam int WQ_W    = 11;
    localparam int GP_W    = 48;
    localparam int HW      = GP_W / 2;
    localparam int FRAC    = 16;
    localparam int PQ_W    = 32 + C_W;
    localparam int TQ_W    = PQ_W - FRAC;
    localparam int MOD_STG = FRAC;
    localparam logic [C_W-1:0] CFG_RST = 11'd64;

    typedef enum logic [1:0] {
        CFG_FLOOR_W,
        CFG_FLOOR_H,
        CFG_CEIL_W,
        CFG_CEIL_H
    } t_cfg_idx;

    typedef enum logic [1:0] {
        SURF_WALL  = 2'd0,
        SURF_FLOOR = 2'd1,
        SURF_CEIL  = 2'd2
    } t_surf;

    typedef struct packed {
        logic [C_W-1:0] fw;
        logic [C_W-1:0] fh;
        logic [C_W-1:0] cw;
        logic [C_W-1:0] ch;
    } t_cfg;

    typedef struct packed {
        logic [9:0]  col;
        logic [9:0]  row;
        logic        is_floor;
        logic [9:0]  tex_u;
        logic        neg;
        logic        zero;
        logic [31:0] px;
        logic [31:0] py;
        logic [32:0] dx;
        logic [32:0] dy;
    } t_pl;

    typedef struct packed {
        logic [WN_W-1:0]  wrem;
        logic [WD_W-1:0]  wden;
        logic [WQ_W-1:0]  wq;
        logic [NUM_W-1:0] frem;
        logic [D_W-1:0]   fden;
        logic [NUM_W-1:0] fq;
    } t_dv;

    typedef struct packed {
        logic v;
        t_pl  pl;
        t_dv  dv;
    } t_dstg;

    typedef struct packed {
        logic                 v;
        logic [9:0]           col;
        logic [9:0]           row;
        logic                 is_floor;
        logic [9:0]           tex_u;
        logic [9:0]           wall_v;
        logic [3:0][TQ_W-1:0] rem;
    } t_mstg;

endpackage

/* rtl/rccm_if.sv */
// Request and result channel interfaces of the column texel mapper.
interface rccm_req_if;
    logic        valid;
    logic        ready;
    logic [9:0]  screen_col;
    logic [9:0]  screen_row;
    logic        wall_textured;
    logic [15:0] wall_height;
    logic [9:0]  wall_tex_u;
    logic [10:0] wall_tex_height;
    logic [31:0] ray_distance;
    logic [31:0] floor_hit_x;
    logic [31:0] floor_hit_y;
    logic [31:0] viewer_x;
    logic [31:0] viewer_y;

    modport source (
        output valid, screen_col, screen_row, wall_textured, wall_height, wall_tex_u,
               wall_tex_height, ray_distance, floor_hit_x, floor_hit_y, viewer_x, viewer_y,
        input  ready
    );
    modport sink (
        input  valid, screen_col, screen_row, wall_textured, wall_height, wall_tex_u,
               wall_tex_height, ray_distance, floor_hit_x, floor_hit_y, viewer_x, viewer_y,
        output ready
    );
endinterface

interface rccm_res_if;
    logic       valid;
    logic       ready;
    logic [9:0] out_col;
    logic [9:0] out_row;
    logic [1:0] surface;
    logic [9:0] texel_u;
    logic [9:0] texel_v;
    logic       last_of_run;

    modport source (
        output valid, out_col, out_row, surface, texel_u, texel_v, last_of_run,
        input  ready
    );
    modport sink (
        input  valid, out_col, out_row, surface, texel_u, texel_v, last_of_run,
        output ready
    );
endinterface

/* rtl/rccm_front.sv */
// Front stages: wall span classification, wall numerator and floor denominator products.
module rccm_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    rccm_req_if.sink          i_req,
    output rccm_pkg::t_dstg   o_stg
);
    localparam int SH   = rccm_pkg::SCR_H;
    localparam int AD_W = rccm_pkg::AD_W;
    localparam int D_W  = rccm_pkg::D_W;
    localparam int WN_W = rccm_pkg::WN_W;

    logic signed [18:0] w_hs, w_s, w_half, w_endr, w_start, w_end, w_row;
    logic               w_wall, w_floor, w_keep;

    logic        r_a_v;
    logic [9:0]  r_a_col, r_a_row, r_a_tex_u;
    logic        r_a_floor;
    logic [15:0] r_a_h;
    logic [10:0] r_a_th;
    logic [31:0] r_a_dist, r_a_fx, r_a_fy, r_a_px, r_a_py;

    logic signed [18:0] w_base, w_d;
    logic [AD_W-1:0]    w_ad;
    logic [WN_W-1:0]    w_wnum;
    rccm_pkg::t_dstg    n_b, r_b;

    assign i_req.ready = i_adv;

    always_comb begin
        w_hs    = $signed({3'b000, i_req.wall_height});
        w_s     = $signed(19'(SH)) - w_hs;
        // halve toward zero
        w_half  = w_s[18] ? ((w_s + 19'sd1) >>> 1) : (w_s >>> 1);
        w_endr  = w_half + w_hs;
        w_start = w_half[18] ? 19'sd0 : w_half;
        w_end   = (w_endr > $signed(19'(SH - 1))) ? $signed(19'(SH - 1)) : w_endr;
        w_row   = $signed({9'b0, i_req.screen_row});
        w_wall  = (w_row >= w_start) && (w_row < w_end);
        w_floor = !w_wall && (w_row >= w_end);
        w_keep  = i_req.wall_textured && (w_row < $signed(19'(SH))) && (w_wall || w_floor);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (i_adv) begin
            r_a_v <= i_req.valid && w_keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_a_col   <= i_req.screen_col;
            r_a_row   <= i_req.screen_row;
            r_a_tex_u <= i_req.wall_tex_u;
            r_a_floor <= w_floor;
            r_a_h     <= i_req.wall_height;
            r_a_th    <= i_req.wall_tex_height;
            r_a_dist  <= i_req.ray_distance;
            r_a_fx    <= i_req.floor_hit_x;
            r_a_fy    <= i_req.floor_hit_y;
            r_a_px    <= i_req.viewer_x;
            r_a_py    <= i_req.viewer_y;
        end
    end

    always_comb begin
        w_base = $signed({8'b0, r_a_row, 1'b0}) - $signed(19'(SH)) + $signed({3'b000, r_a_h});
        w_d    = $signed({8'b0, r_a_row, 1'b0}) - $signed(19'(SH));
        w_ad   = w_d[18] ? AD_W'(-w_d) : AD_W'(w_d);
        w_wnum = (w_base > 19'sd0) ? (WN_W'(w_base[16:0]) * WN_W'(r_a_th)) : '0;

        n_b             = '0;
        n_b.v           = r_a_v;
        n_b.pl.col      = r_a_col;
        n_b.pl.row      = r_a_row;
        n_b.pl.is_floor = r_a_floor;
        n_b.pl.tex_u    = r_a_tex_u;
        n_b.pl.neg      = w_d[18];
        n_b.pl.zero     = (w_ad == '0) || (r_a_dist == '0);
        n_b.pl.px       = r_a_px;
        n_b.pl.py       = r_a_py;
        n_b.pl.dx       = {1'b0, r_a_fx} - {1'b0, r_a_px};
        n_b.pl.dy       = {1'b0, r_a_fy} - {1'b0, r_a_py};
        n_b.dv.wrem     = w_wnum;
        n_b.dv.wden     = {r_a_h, 1'b0};
        n_b.dv.fden     = D_W'(w_ad) * D_W'(r_a_dist);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b.v <= 1'b0;
        end else if (i_adv) begin
            r_b <= n_b;
        end
    end

    assign o_stg = r_b;

endmodule

/* rtl/rccm_div.sv */
// Pipelined dividers: one perspective weight bit per stage, one wall texel bit per stage in the first WQ_W.
module rccm_div (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  rccm_pkg::t_dstg i_stg,
    output rccm_pkg::t_dstg o_stg
);
    localparam int NUM_W = rccm_pkg::NUM_W;
    localparam int WN_W  = rccm_pkg::WN_W;
    localparam int WQ_W  = rccm_pkg::WQ_W;

    rccm_pkg::t_dstg r_stg [NUM_W];

    for (genvar k = 0; k < NUM_W; k++) begin : g_stg
        localparam int FB = NUM_W - 1 - k;
        rccm_pkg::t_dstg  w_in, n_stg;
        logic [NUM_W:0]   w_sh;
        logic [WN_W-1:0]  w_wrem;
        logic [WQ_W-1:0]  w_wq;

        if (k == 0) begin : g_first
            assign w_in = i_stg;
        end else begin : g_next
            assign w_in = r_stg[k-1];
        end

        if (k < WQ_W) begin : g_wall
            localparam int WB = WQ_W - 1 - k;
            logic [WN_W-1:0] w_wd;
            always_comb begin
                w_wd   = WN_W'(w_in.dv.wden) << WB;
                w_wrem = w_in.dv.wrem;
                w_wq   = w_in.dv.wq;
                if (w_in.dv.wrem >= w_wd) begin
                    w_wrem   = w_in.dv.wrem - w_wd;
                    w_wq[WB] = 1'b1;
                end
            end
        end else begin : g_pass
            assign w_wrem = w_in.dv.wrem;
            assign w_wq   = w_in.dv.wq;
        end

        // long division of the constant numerator, one bit shifted in per stage
        always_comb begin
            n_stg         = w_in;
            n_stg.dv.wrem = w_wrem;
            n_stg.dv.wq   = w_wq;
            w_sh          = {w_in.dv.frem, rccm_pkg::WQ_NUM[FB]};
            if (w_sh >= {1'b0, w_in.dv.fden}) begin
                n_stg.dv.frem   = NUM_W'(w_sh - {1'b0, w_in.dv.fden});
                n_stg.dv.fq[FB] = 1'b1;
            end else begin
                n_stg.dv.frem = w_sh[NUM_W-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_stg[k].v <= 1'b0;
            end else if (i_adv) begin
                r_stg[k] <= n_stg;
            end
        end
    end

    assign o_stg = r_stg[NUM_W-1];

endmodule

/* rtl/rccm_ground.sv */
// Ground point blend and texture size scaling, five register stages.
module rccm_ground (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  rccm_pkg::t_cfg  i_cfg,
    input  rccm_pkg::t_dstg i_stg,
    output rccm_pkg::t_mstg o_stg
);
    localparam int GP_W = rccm_pkg::GP_W;
    localparam int HW   = rccm_pkg::HW;
    localparam int PQ_W = rccm_pkg::PQ_W;
    localparam int TQ_W = rccm_pkg::TQ_W;
    localparam int FRAC = rccm_pkg::FRAC;

    logic [GP_W-1:0] w_wq;

    logic              r1_v, r2_v, r3_v, r4_v;
    rccm_pkg::t_pl     r1_pl, r2_pl, r3_pl, r4_pl;
    logic [9:0]        r1_wv, r2_wv, r3_wv, r4_wv;
    logic [GP_W-1:0]   r1_a, r1_bx, r1_by;
    logic [GP_W-1:0]   r2_x00, r2_x10, r2_x01, r2_y00, r2_y10, r2_y01;
    logic [GP_W-1:0]   r3_sx, r3_sy;
    logic [31:0]       r4_gx, r4_gy;
    rccm_pkg::t_mstg   n5, r5;

    assign w_wq = GP_W'(i_stg.dv.fq);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5.v <= 1'b0;
        end else if (i_adv) begin
            r1_v <= i_stg.v;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5   <= n5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_pl  <= i_stg.pl;
            r1_wv  <= i_stg.dv.wq[9:0];
            r1_a   <= i_stg.pl.neg ? (GP_W'(0) - w_wq) : w_wq;
            r1_bx  <= {{(GP_W-33){i_stg.pl.dx[32]}}, i_stg.pl.dx};
            r1_by  <= {{(GP_W-33){i_stg.pl.dy[32]}}, i_stg.pl.dy};

            // low half of the product only: the high-high term falls off the top
            r2_pl  <= r1_pl;
            r2_wv  <= r1_wv;
            r2_x00 <= GP_W'(r1_a[HW-1:0])    * GP_W'(r1_bx[HW-1:0]);
            r2_x10 <= GP_W'(r1_a[GP_W-1:HW]) * GP_W'(r1_bx[HW-1:0]);
            r2_x01 <= GP_W'(r1_a[HW-1:0])    * GP_W'(r1_bx[GP_W-1:HW]);
            r2_y00 <= GP_W'(r1_a[HW-1:0])    * GP_W'(r1_by[HW-1:0]);
            r2_y10 <= GP_W'(r1_a[GP_W-1:HW]) * GP_W'(r1_by[HW-1:0]);
            r2_y01 <= GP_W'(r1_a[HW-1:0])    * GP_W'(r1_by[GP_W-1:HW]);

            r3_pl  <= r2_pl;
            r3_wv  <= r2_wv;
            r3_sx  <= r2_x00 + ((r2_x10 + r2_x01) << HW);
            r3_sy  <= r2_y00 + ((r2_y10 + r2_y01) << HW);

            r4_pl  <= r3_pl;
            r4_wv  <= r3_wv;
            r4_gx  <= r3_pl.px + r3_sx[FRAC+31:FRAC];
            r4_gy  <= r3_pl.py + r3_sy[FRAC+31:FRAC];
        end
    end

    always_comb begin
        n5          = '0;
        n5.v        = r4_v;
        n5.col      = r4_pl.col;
        n5.row      = r4_pl.row;
        n5.is_floor = r4_pl.is_floor;
        n5.tex_u    = r4_pl.tex_u;
        n5.wall_v   = r4_wv;
        if (!r4_pl.zero) begin
            n5.rem[0] = TQ_W'((PQ_W'(r4_gx) * PQ_W'(i_cfg.fw)) >> FRAC);
            n5.rem[1] = TQ_W'((PQ_W'(r4_gy) * PQ_W'(i_cfg.fh)) >> FRAC);
            n5.rem[2] = TQ_W'((PQ_W'(r4_gx) * PQ_W'(i_cfg.cw)) >> FRAC);
            n5.rem[3] = TQ_W'((PQ_W'(r4_gy) * PQ_W'(i_cfg.ch)) >> FRAC);
        end
    end

    assign o_stg = r5;

endmodule

/* rtl/rccm_mod.sv */
// Pipelined modulo by texture size for the four floor and ceiling lanes.
module rccm_mod (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  rccm_pkg::t_cfg  i_cfg,
    input  rccm_pkg::t_mstg i_stg,
    output rccm_pkg::t_mstg o_stg
);
    localparam int MOD_STG = rccm_pkg::MOD_STG;
    localparam int TQ_W    = rccm_pkg::TQ_W;
    localparam int C_W     = rccm_pkg::C_W;

    logic [C_W-1:0]  w_size [4];
    rccm_pkg::t_mstg r_stg [MOD_STG];

    assign w_size[0] = i_cfg.fw;
    assign w_size[1] = i_cfg.fh;
    assign w_size[2] = i_cfg.cw;
    assign w_size[3] = i_cfg.ch;

    for (genvar k = 0; k < MOD_STG; k++) begin : g_stg
        localparam int SB = MOD_STG - 1 - k;
        rccm_pkg::t_mstg w_in, n_stg;
        logic [TQ_W-1:0] w_sz [4];

        if (k == 0) begin : g_first
            assign w_in = i_stg;
        end else begin : g_next
            assign w_in = r_stg[k-1];
        end

        always_comb begin
            n_stg = w_in;
            for (int l = 0; l < 4; l++) begin
                w_sz[l] = TQ_W'(w_size[l]) << SB;
                if (w_in.rem[l] >= w_sz[l]) begin
                    n_stg.rem[l] = w_in.rem[l] - w_sz[l];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_stg[k].v <= 1'b0;
            end else if (i_adv) begin
                r_stg[k] <= n_stg;
            end
        end
    end

    assign o_stg = r_stg[MOD_STG-1];

endmodule

/* rtl/raycast_column_texel_mapper.sv */
// Top level of the column texel mapper: config registers, pipeline and result beat unit.
// Pipeline from request beat to result beat: 2 front, 41 divider, 5 ground and 16 modulo
// stages, then the output register.
// Throughput: one request per cycle on wall rows unless stalled; floor rows send two beats.
// Reset: synchronous active low, clears all valid bits; texture sizes return to 64.
module raycast_column_texel_mapper (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [10:0] i_cfg_data,
    rccm_req_if.sink    i_req,
    rccm_res_if.source  o_res
);
    localparam int SH = rccm_pkg::SCR_H;

    rccm_pkg::t_cfg  r_cfg;
    rccm_pkg::t_dstg w_front, w_div;
    rccm_pkg::t_mstg w_gnd, w_mod;
    rccm_pkg::t_mstg r_e;
    logic            r_e_phase;
    logic            w_adv, w_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fw <= rccm_pkg::CFG_RST;
            r_cfg.fh <= rccm_pkg::CFG_RST;
            r_cfg.cw <= rccm_pkg::CFG_RST;
            r_cfg.ch <= rccm_pkg::CFG_RST;
        end else if (i_cfg_we) begin
            unique case (rccm_pkg::t_cfg_idx'(i_cfg_idx))
                rccm_pkg::CFG_FLOOR_W: r_cfg.fw <= i_cfg_data;
                rccm_pkg::CFG_FLOOR_H: r_cfg.fh <= i_cfg_data;
                rccm_pkg::CFG_CEIL_W:  r_cfg.cw <= i_cfg_data;
                rccm_pkg::CFG_CEIL_H:  r_cfg.ch <= i_cfg_data;
            endcase
        end
    end

    rccm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_req   (i_req),
        .o_stg   (w_front)
    );

    rccm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_stg   (w_front),
        .o_stg   (w_div)
    );

    rccm_ground u_ground (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_cfg   (r_cfg),
        .i_stg   (w_div),
        .o_stg   (w_gnd)
    );

    rccm_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_cfg   (r_cfg),
        .i_stg   (w_gnd),
        .o_stg   (w_mod)
    );

    // a floor item leaves as a floor beat then a ceiling beat
    assign w_done = o_res.ready && (!r_e.is_floor || r_e_phase);
    assign w_adv  = !r_e.v || w_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e.v     <= 1'b0;
            r_e_phase <= 1'b0;
        end else if (w_adv) begin
            r_e       <= w_mod;
            r_e_phase <= 1'b0;
        end else if (o_res.ready) begin
            r_e_phase <= 1'b1;
        end
    end

    always_comb begin
        o_res.valid       = r_e.v;
        o_res.out_col     = r_e.col;
        o_res.last_of_run = !r_e.is_floor || r_e_phase;
        if (!r_e.is_floor) begin
            o_res.out_row = r_e.row;
            o_res.surface = rccm_pkg::SURF_WALL;
            o_res.texel_u = r_e.tex_u;
            o_res.texel_v = r_e.wall_v;
        end else if (!r_e_phase) begin
            o_res.out_row = r_e.row;
            o_res.surface = rccm_pkg::SURF_FLOOR;
            o_res.texel_u = r_e.rem[0][9:0];
            o_res.texel_v = r_e.rem[1][9:0];
        end else begin
            o_res.out_row = 10'(SH - int'(r_e.row));
            o_res.surface = rccm_pkg::SURF_CEIL;
            o_res.texel_u = r_e.rem[2][9:0];
            o_res.texel_v = r_e.rem[3][9:0];
        end
    end

endmodule

/* test/tb.sv */
// Self-checking testbench for the raycast column texel mapper.
`timescale 1ns / 100ps

module tb;

    typedef struct {
        logic [9:0]  col;
        logic [9:0]  row;
        logic        textured;
        logic [15:0] height;
        logic [9:0]  tex_u;
        logic [10:0] tex_h;
        logic [31:0] ray_dist;
        logic [31:0] fx;
        logic [31:0] fy;
        logic [31:0] px;
        logic [31:0] py;
    } t_pixel_req;

    typedef struct {
        logic [9:0]      col;
        logic [9:0]      row;
        rccm_pkg::t_surf surf;
        logic [9:0]      u;
        logic [9:0]      v;
        logic            last;
    } t_texel;

    class t_texel_scoreboard;
        t_texel      texel_q[$];
        logic [10:0] tex_size[4];
        int          mismatches;
        int          beats_seen;

        function new();
            foreach (tex_size[i]) tex_size[i] = rccm_pkg::CFG_RST;
            mismatches = 0;
            beats_seen = 0;
        endfunction

        function void set_size(rccm_pkg::t_cfg_idx idx, logic [10:0] val);
            tex_size[idx] = val;
        endfunction

        function logic [31:0] ground(logic [63:0] wq, logic [31:0] hit, logic [31:0] pos0);
            logic [63:0] prod;
            prod = wq * ({32'd0, hit} - {32'd0, pos0});
            return pos0 + prod[47:16];
        endfunction

        function logic [9:0] texel_of(logic [31:0] pos, logic [10:0] size);
            logic [63:0] scaled;
            if (size == 0) return 10'd0;
            scaled = ({32'd0, pos} * size) >> 16;
            return 10'(scaled % size);
        endfunction

        // Accepted request: push the texel beats it must produce.
        function void note(t_pixel_req r);
            int          row, h, start, stop, d;
            longint      num, v;
            logic [63:0] ad, wq;
            logic [31:0] gx, gy;
            t_texel      t;
            row = r.row;
            h   = r.height;
            if (!r.textured || row >= rccm_pkg::SCR_H) return;
            start = (rccm_pkg::SCR_H - h) / 2;
            stop  = start + h;
            if (start < 0) start = 0;
            if (stop > rccm_pkg::SCR_H - 1) stop = rccm_pkg::SCR_H - 1;
            t.col = r.col;
            t.row = r.row;
            if (row >= start && row < stop) begin
                num = longint'(2 * row - rccm_pkg::SCR_H + h) * longint'(r.tex_h);
                v   = (num > 0) ? num / (2 * longint'(h)) : 0;
                t.surf = rccm_pkg::SURF_WALL;
                t.u    = r.tex_u;
                t.v    = 10'(v);
                t.last = 1'b1;
                texel_q.push_back(t);
                return;
            end
            if (row < stop) return;
            d  = 2 * row - rccm_pkg::SCR_H;
            ad = (d < 0) ? -d : d;
            t.surf = rccm_pkg::SURF_FLOOR;
            t.u    = '0;
            t.v    = '0;
            t.last = 1'b0;
            // degenerate denominator: all four texels stay 0
            if (ad != 0 && r.ray_dist != 0) begin
                wq = (64'(rccm_pkg::SCR_H) << 32) / (ad * r.ray_dist);
                if (d < 0) wq = -wq;
                gx = ground(wq, r.fx, r.px);
                gy = ground(wq, r.fy, r.py);
                t.u = texel_of(gx, tex_size[rccm_pkg::CFG_FLOOR_W]);
                t.v = texel_of(gy, tex_size[rccm_pkg::CFG_FLOOR_H]);
                texel_q.push_back(t);
                t.u = texel_of(gx, tex_size[rccm_pkg::CFG_CEIL_W]);
                t.v = texel_of(gy, tex_size[rccm_pkg::CFG_CEIL_H]);
            end else begin
                texel_q.push_back(t);
            end
            t.surf = rccm_pkg::SURF_CEIL;
            t.row  = 10'(rccm_pkg::SCR_H - row);
            t.last = 1'b1;
            texel_q.push_back(t);
        endfunction

        function void check(t_texel got);
            t_texel want;
            beats_seen++;
            if (texel_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat col=%0d row=%0d surf=%0d u=%0d v=%0d last=%0b",
                             got.col, got.row, got.surf, got.u, got.v, got.last);
                return;
            end
            want = texel_q.pop_front();
            if (got.col !== want.col || got.row !== want.row || got.surf !== want.surf ||
                got.u !== want.u || got.v !== want.v || got.last !== want.last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("beat mismatch exp col=%0d row=%0d surf=%0d u=%0d v=%0d last=%0b",
                             want.col, want.row, want.surf, want.u, want.v, want.last,
                             " got col=%0d row=%0d surf=%0d u=%0d v=%0d last=%0b",
                             got.col, got.row, got.surf, got.u, got.v, got.last);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [10:0] i_cfg_data;
    bit          no_idle = 1'b0;
    int          cycles = 0;
    int          reqs_sent = 0;

    rccm_req_if req();
    rccm_res_if res();

    t_texel_scoreboard sb = new();

    raycast_column_texel_mapper DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req),
        .o_res      (res)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("timeout after %0d cycles", cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_texel t;
        if (i_rst_n && res.valid && res.ready) begin
            t.col  = res.out_col;
            t.row  = res.out_row;
            t.surf = rccm_pkg::t_surf'(res.surface);
            t.u    = res.texel_u;
            t.v    = res.texel_v;
            t.last = res.last_of_run;
            sb.check(t);
        end
    end

    // result side backpressure
    initial begin
        res.ready <= 1'b1;
        @(posedge i_clk);
        forever begin
            if (!no_idle && $urandom_range(0, 3) == 0) begin
                res.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end
            res.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
        end
    end

    task automatic send(t_pixel_req r);
        if (!no_idle && $urandom_range(0, 4) == 0) begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        req.screen_col      <= r.col;
        req.screen_row      <= r.row;
        req.wall_textured   <= r.textured;
        req.wall_height     <= r.height;
        req.wall_tex_u      <= r.tex_u;
        req.wall_tex_height <= r.tex_h;
        req.ray_distance    <= r.ray_dist;
        req.floor_hit_x     <= r.fx;
        req.floor_hit_y     <= r.fy;
        req.viewer_x        <= r.px;
        req.viewer_y        <= r.py;
        req.valid           <= 1'b1;
        do @(posedge i_clk); while (!req.ready);
        sb.note(r);
        reqs_sent++;
    endtask

    // Only once the pipeline has drained; rows that give no beat may still be in flight.
    task automatic set_sizes(logic [10:0] fw, logic [10:0] fh, logic [10:0] cw, logic [10:0] ch);
        logic [10:0] vals[4];
        vals = '{fw, fh, cw, ch};
        req.valid <= 1'b0;
        while (sb.texel_q.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        for (int i = 0; i < 4; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= 2'(i);
            i_cfg_data <= vals[i];
            sb.set_size(rccm_pkg::t_cfg_idx'(i), vals[i]);
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_pixel_req rand_pixel();
        t_pixel_req r;
        r.col      = 10'($urandom);
        r.row      = ($urandom_range(0, 9) == 0) ? 10'($urandom) : 10'($urandom_range(0, 479));
        r.textured = ($urandom_range(0, 9) != 0);
        case ($urandom_range(0, 4))
            0: r.height = 16'($urandom_range(0, 6));
            1: r.height = 16'($urandom);
            default: r.height = 16'($urandom_range(0, 600));
        endcase
        r.tex_u = 10'($urandom);
        r.tex_h = ($urandom_range(0, 7) == 0) ? 11'($urandom) : 11'($urandom_range(1, 1024));
        case ($urandom_range(0, 9))
            0: r.ray_dist = $urandom;
            1: r.ray_dist = 32'($urandom_range(0, 2));
            default: r.ray_dist = 32'($urandom_range(32'h1000, 32'h28_0000));
        endcase
        r.fx = $urandom;
        r.fy = $urandom;
        r.px = $urandom;
        r.py = $urandom;
        return r;
    endfunction

    function automatic t_pixel_req mk(int col, int row, bit tx, int h, int th,
                                      logic [31:0] rdist, logic [31:0] pos);
        t_pixel_req r;
        r = rand_pixel();
        r.col = 10'(col);
        r.row = 10'(row);
        r.textured = tx;
        r.height = 16'(h);
        r.tex_h = 11'(th);
        r.ray_dist = rdist;
        r.fx = pos;
        r.py = ~pos;
        return r;
    endfunction

    initial begin
        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= '0;
        i_cfg_data <= '0;
        req.valid  <= 1'b0;
        req.screen_col <= '0; req.screen_row <= '0; req.wall_textured <= 1'b0;
        req.wall_height <= '0; req.wall_tex_u <= '0; req.wall_tex_height <= '0;
        req.ray_distance <= '0; req.floor_hit_x <= '0; req.floor_hit_y <= '0;
        req.viewer_x <= '0; req.viewer_y <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes, wall / floor / untextured, zero denominator, odd split
        send(mk(0,    0,    1, 480,   1,    32'h1_0000, 32'h0));
        send(mk(1023, 479,  1, 100,   1024, 32'h1_0000, 32'hFFFF_FFFF));
        send(mk(5,    480,  1, 100,   64,   32'h1_0000, 32'h1234_5678));
        send(mk(6,    1023, 1, 100,   64,   32'h1_0000, 32'h1234_5678));
        send(mk(7,    300,  0, 100,   64,   32'h1_0000, 32'h1234_5678));
        send(mk(8,    240,  1, 0,     64,   32'h1_0000, 32'h8000_0000));
        send(mk(9,    239,  1, 1,     64,   32'h1_0000, 32'h8000_0000));
        send(mk(10,   240,  1, 1,     2047, 32'h1_0000, 32'h8000_0000));
        send(mk(11,   0,    1, 65535, 1024, 32'h1_0000, 32'h0));
        send(mk(12,   478,  1, 65535, 0,    32'h1_0000, 32'h0));
        send(mk(13,   300,  1, 50,    64,   32'h0,      32'h4000_0000));
        send(mk(14,   300,  1, 50,    64,   32'h1,      32'h4000_0000));
        send(mk(15,   300,  1, 50,    64,   32'hFFFF_FFFF, 32'h4000_0000));
        send(mk(16,   100,  1, 20,    64,   32'h2_0000, 32'hC000_0000));
        send(mk(17,   10,   1, 479,   2047, 32'h3_0000, 32'h1));
        send(mk(18,   260,  1, 2,     3,    32'h8000,   32'hFFFF_0000));
        send(mk(19,   200,  1, 600,   1000, 32'h1_0000, 32'h0));
        send(mk(20,   479,  1, 0,     1,    32'h10_0000, 32'hFFFF_FFFF));

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_sizes(11'd1, 11'd1, 11'd1, 11'd1);
                1: set_sizes(11'd1024, 11'd1024, 11'd1024, 11'd1024);
                2: set_sizes(11'd0, 11'd2047, 11'd1025, 11'd3);
                3: set_sizes(11'd64, 11'd32, 11'd128, 11'd7);
                4: set_sizes(11'($urandom), 11'($urandom), 11'($urandom_range(1, 1024)),
                             11'($urandom_range(1, 1024)));
                default: begin
                    set_sizes(11'($urandom_range(1, 1024)), 11'($urandom_range(1, 1024)),
                              11'($urandom_range(1, 1024)), 11'($urandom_range(1, 1024)));
                    no_idle = 1'b1;
                end
            endcase
            repeat (185) send(rand_pixel());
        end
        req.valid <= 1'b0;

        while (sb.texel_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        $display("Run sent %0d pixel requests and checked %0d texel beats over 7 size settings.",
                 reqs_sent, sb.beats_seen);
        $display("Mismatch count: %0d", sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/rccm_pkg.sv
rtl/rccm_if.sv
rtl/rccm_front.sv
rtl/rccm_div.sv
rtl/rccm_ground.sv
rtl/rccm_mod.sv
rtl/raycast_column_texel_mapper.sv
test/tb.sv
